[hdl/scrb_pkg.sv]
// Shared types, constants and helper functions of the serial channel register block.
package scrb_pkg;

  // Sizes
  localparam int NUM_CHANNELS = 4;
  localparam int BUFFER_WORDS = 32;
  localparam int BUF_AW       = $clog2(BUFFER_WORDS);
  localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  // Register offsets
  localparam logic [7:0] OFS_POLL   = 8'h30;
  localparam logic [7:0] OFS_CSR    = 8'h34;
  localparam logic [7:0] OFS_STATUS = 8'h38;
  localparam logic [7:0] OFS_CLOCK  = 8'h3C;
  localparam logic [7:0] OFS_BUF    = 8'h80;

  // Register values and masks
  localparam logic [31:0] UNKNOWN_READ = 32'hDEAD_BEEF;
  localparam logic [31:0] POLL_RESET   = 32'h0007_0000;
  localparam logic [31:0] CSR_KEEP     = 32'h487F_7F06;
  localparam logic [31:0] STAT_ERR     = 32'h0F0F_0F0F;
  localparam logic [31:0] STAT_READY   = 32'h2020_2020;
  localparam logic [31:0] STAT_WR_CLR  = 32'h9010_1010;
  localparam logic [31:0] STAT_UNUSED  = 32'hD0D0_D0D0;

  // Control word bit positions
  localparam int CSR_START     = 0;
  localparam int CSR_RDSTINTMK = 27;
  localparam int CSR_RDSTINT   = 28;
  localparam int CSR_COMERR    = 29;
  localparam int CSR_TCINTMSK  = 30;
  localparam int CSR_TCINT     = 31;
  localparam int STAT_START    = 31;

  // Input item commands
  typedef enum logic [1:0] {
    CMD_BUS_RD  = 2'd0,
    CMD_BUS_WR  = 2'd1,
    CMD_DEV_UPD = 2'd2,
    CMD_DEV_CHG = 2'd3
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_XFER = 2'd2
  } kind_t;

  // Word of a channel
  typedef enum logic [1:0] {
    SUB_OUT     = 2'd0,
    SUB_IN_HIGH = 2'd1,
    SUB_IN_LOW  = 2'd2
  } sub_t;

  // Classified operation handed from the front end to the back end
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_BUF_RD  = 4'd1,
    OP_BUF_WR  = 4'd2,
    OP_CH_RD   = 4'd3,
    OP_CH_WR   = 4'd4,
    OP_POLL_RD = 4'd5,
    OP_POLL_WR = 4'd6,
    OP_CLK_RD  = 4'd7,
    OP_CLK_WR  = 4'd8,
    OP_STAT_RD = 4'd9,
    OP_STAT_WR = 4'd10,
    OP_CSR_RD  = 4'd11,
    OP_CSR_WR  = 4'd12,
    OP_UNK_RD  = 4'd13,
    OP_DEV_UPD = 4'd14,
    OP_DEV_CHG = 4'd15
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        chan;
    sub_t              sub;
    logic [BUF_AW-1:0] buf_idx;
    logic [31:0]       wdata;
    logic [31:0]       dhigh;
    logic [31:0]       dlow;
    logic              dvalid;
  } op_item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    op_item_t item;
  } queue_head_t;

  // Transfer length: a field of zero means 128 bytes, otherwise n+1.
  function automatic logic [7:0] trans_len(input logic [6:0] field);
    logic [7:0] len;
    len = (field == 7'd0) ? 8'd128 : ({1'b0, field} + 8'd1);
    return len;
  endfunction

  // Any channel ready.
  function automatic logic any_ready(input logic [31:0] status);
    logic hit;
    hit = |(status & STAT_READY);
    return hit;
  endfunction

  // Interrupt line from the control word.
  function automatic logic irq_of(input logic [31:0] csr);
    logic line;
    line = (csr[CSR_RDSTINT] & csr[CSR_RDSTINTMK]) | (csr[CSR_TCINT] & csr[CSR_TCINTMSK]);
    return line;
  endfunction

endpackage

[hdl/scrb_front.sv]
// Front end: accepts input items, classifies them and queues the operations.
module scrb_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  logic [7:0]             in_address,
  input  logic [31:0]            in_write_data,
  input  logic [1:0]             in_channel,
  input  logic [31:0]            in_data_high,
  input  logic [31:0]            in_data_low,
  input  logic                   in_data_valid,
  output scrb_pkg::queue_head_t  head,
  input  logic                   pop
);
  import scrb_pkg::*;

  op_item_t             dec;
  logic [3:0]           word_idx;
  logic [1:0]           dec_ch;
  logic [1:0]           dec_sub;
  logic                 ch_reg_hit;
  logic                 is_wr;

  op_item_t             q_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_nxt;
  logic [QUEUE_CW-1:0]  cnt_r;
  logic [QUEUE_CW-1:0]  cnt_nxt;
  logic                 push;

  // Split a low register offset into channel and word: three words per channel.
  always_comb begin
    word_idx = in_address[5:2];
    if (word_idx >= 4'd9) begin
      dec_ch  = 2'd3;
      dec_sub = 2'(word_idx - 4'd9);
    end else if (word_idx >= 4'd6) begin
      dec_ch  = 2'd2;
      dec_sub = 2'(word_idx - 4'd6);
    end else if (word_idx >= 4'd3) begin
      dec_ch  = 2'd1;
      dec_sub = 2'(word_idx - 4'd3);
    end else begin
      dec_ch  = 2'd0;
      dec_sub = 2'(word_idx);
    end
    ch_reg_hit = (in_address < OFS_POLL) && (in_address[1:0] == 2'b00) &&
                 (int'(dec_ch) < NUM_CHANNELS);
  end

  // Classify the incoming item.
  always_comb begin
    dec         = '0;
    dec.op      = OP_NOP;
    dec.sub     = SUB_OUT;
    dec.wdata   = in_write_data;
    dec.dhigh   = in_data_high;
    dec.dlow    = in_data_low;
    dec.dvalid  = in_data_valid;
    dec.buf_idx = in_address[2 +: BUF_AW];
    is_wr       = (cmd_t'(in_cmd) == CMD_BUS_WR);
    unique case (cmd_t'(in_cmd))
      CMD_BUS_RD, CMD_BUS_WR: begin
        if (in_address >= OFS_BUF) begin
          dec.op = is_wr ? OP_BUF_WR : OP_BUF_RD;
        end else if (ch_reg_hit) begin
          dec.op   = is_wr ? OP_CH_WR : OP_CH_RD;
          dec.chan = dec_ch;
          dec.sub  = sub_t'(dec_sub);
        end else if (in_address == OFS_POLL) begin
          dec.op = is_wr ? OP_POLL_WR : OP_POLL_RD;
        end else if (in_address == OFS_CLOCK) begin
          dec.op = is_wr ? OP_CLK_WR : OP_CLK_RD;
        end else if (in_address == OFS_STATUS) begin
          dec.op = is_wr ? OP_STAT_WR : OP_STAT_RD;
        end else if (in_address == OFS_CSR) begin
          dec.op = is_wr ? OP_CSR_WR : OP_CSR_RD;
        end else begin
          dec.op = is_wr ? OP_NOP : OP_UNK_RD;
        end
      end
      CMD_DEV_UPD, CMD_DEV_CHG: begin
        if (int'(in_channel) < NUM_CHANNELS) begin
          dec.op   = (cmd_t'(in_cmd) == CMD_DEV_UPD) ? OP_DEV_UPD : OP_DEV_CHG;
          dec.chan = in_channel;
        end
      end
      default: dec.op = OP_NOP;
    endcase
  end

  // Operation queue between front and back end.
  assign in_ready   = (int'(cnt_r) < QUEUE_DEPTH);
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[hdl/scrb_back.sv]
// Back end: register state, transfer buffer, command sequencer and result register.
module scrb_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  scrb_pkg::queue_head_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_kind,
  output logic [31:0]            out_read_data,
  output logic [1:0]             out_target_channel,
  output logic [31:0]            out_command_word,
  output logic                   out_poll_enable,
  output logic [7:0]             out_in_length,
  output logic [7:0]             out_out_length,
  output logic                   out_irq,
  output logic                   out_last
);
  import scrb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUF  = 3'b010,
    S_CMD  = 3'b100
  } state_t;

  op_item_t            it;
  state_t              state_r;
  state_t              state_nxt;
  logic [1:0]          cnt_r;
  logic [1:0]          cnt_nxt;

  // Register state
  logic [31:0]         out_words_r [NUM_CHANNELS];
  logic [31:0]         in_high_r   [NUM_CHANNELS];
  logic [31:0]         in_low_r    [NUM_CHANNELS];
  logic [31:0]         poll_r;
  logic [31:0]         poll_nxt;
  logic [31:0]         csr_r;
  logic [31:0]         csr_nxt;
  logic [31:0]         status_r;
  logic [31:0]         status_nxt;
  logic [31:0]         clk_lock_r;
  logic [31:0]         clk_lock_nxt;

  // Channel word write ports
  logic                ow_we;
  logic [31:0]         ow_wd;
  logic                ih_we;
  logic [31:0]         ih_wd;
  logic                il_we;
  logic [31:0]         il_wd;
  logic [1:0]          rd_ch;
  logic [CH_AW-1:0]    ch_idx;
  logic [31:0]         ch_word;

  // Transfer buffer
  logic [31:0]         buf_mem [BUFFER_WORDS];
  logic [BUFFER_WORDS-1:0] buf_vld_r;
  logic [31:0]         buf_rdata_r;
  logic                buf_hit_r;
  logic                buf_we;

  // Result register
  logic                out_free;
  logic                ld_en;
  kind_t               ld_kind;
  logic [31:0]         ld_rdata;
  logic [1:0]          ld_tch;
  logic [31:0]         ld_cw;
  logic                ld_pe;
  logic [7:0]          ld_il;
  logic [7:0]          ld_ol;
  logic                ld_last;
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [31:0]         out_rdata_r;
  logic [1:0]          out_tch_r;
  logic [31:0]         out_cw_r;
  logic                out_pe_r;
  logic [7:0]          out_il_r;
  logic [7:0]          out_ol_r;
  logic                out_irq_r;
  logic                out_last_r;

  assign it       = head.item;
  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == S_IDLE) && head.valid && out_free;
  assign buf_we   = pop && (it.op == OP_BUF_WR);

  // One channel read index: the sequencer's channel while emitting commands.
  assign rd_ch  = (state_r == S_CMD) ? cnt_r : it.chan;
  assign ch_idx = rd_ch[CH_AW-1:0];

  always_comb begin
    case (it.sub)
      SUB_OUT:     ch_word = out_words_r[ch_idx];
      SUB_IN_HIGH: ch_word = in_high_r[ch_idx];
      default:     ch_word = in_low_r[ch_idx];
    endcase
  end

  // Execute the operation at the queue head and sequence its results.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    poll_nxt     = poll_r;
    csr_nxt      = csr_r;
    status_nxt   = status_r;
    clk_lock_nxt = clk_lock_r;
    ow_we        = 1'b0;
    ow_wd        = it.wdata;
    ih_we        = 1'b0;
    ih_wd        = it.wdata;
    il_we        = 1'b0;
    il_wd        = it.wdata;
    ld_en        = 1'b0;
    ld_kind      = KIND_ACK;
    ld_rdata     = '0;
    ld_tch       = '0;
    ld_cw        = '0;
    ld_pe        = 1'b0;
    ld_il        = '0;
    ld_ol        = '0;
    ld_last      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          ld_en = 1'b1;
          unique case (it.op)
            OP_NOP, OP_BUF_WR: begin
            end
            OP_BUF_RD: begin
              ld_en     = 1'b0;
              state_nxt = S_BUF;
            end
            OP_CH_RD: begin
              ld_rdata = ch_word;
              if (it.sub != SUB_OUT) begin
                status_nxt[{~it.chan, 3'd5}] = 1'b0;
                csr_nxt[CSR_RDSTINT]         = any_ready(status_nxt);
              end
            end
            OP_CH_WR: begin
              ow_we = (it.sub == SUB_OUT);
              ih_we = (it.sub == SUB_IN_HIGH);
              il_we = (it.sub == SUB_IN_LOW);
            end
            OP_POLL_RD: ld_rdata = poll_r;
            OP_POLL_WR: poll_nxt = it.wdata;
            OP_CLK_RD:  ld_rdata = clk_lock_r;
            OP_CLK_WR:  clk_lock_nxt = it.wdata;
            OP_STAT_RD: ld_rdata = status_r;
            OP_STAT_WR: begin
              status_nxt = status_r & ~(it.wdata & STAT_ERR);
              if (it.wdata[STAT_START]) begin
                // Start of the command burst: channel zero goes out first.
                status_nxt = status_nxt & ~STAT_WR_CLR;
                ld_kind    = KIND_CMD;
                ld_tch     = rd_ch;
                ld_cw      = out_words_r[ch_idx];
                ld_pe      = poll_r[5'd7 - 5'(rd_ch)];
                ld_last    = (NUM_CHANNELS == 1);
                cnt_nxt    = 2'd1;
                state_nxt  = (NUM_CHANNELS == 1) ? S_IDLE : S_CMD;
              end
            end
            OP_CSR_RD: ld_rdata = csr_r;
            OP_CSR_WR: begin
              csr_nxt             = (csr_r & ~CSR_KEEP) | (it.wdata & CSR_KEEP);
              csr_nxt[CSR_COMERR] = 1'b0;
              if (it.wdata[CSR_RDSTINT]) begin
                csr_nxt[CSR_RDSTINT] = 1'b0;
              end
              if (it.wdata[CSR_TCINT]) begin
                csr_nxt[CSR_TCINT] = 1'b0;
              end
              if (it.wdata[CSR_START]) begin
                ld_kind            = KIND_XFER;
                ld_tch             = csr_nxt[2:1];
                ld_il              = trans_len(csr_nxt[14:8]);
                ld_ol              = trans_len(csr_nxt[22:16]);
                csr_nxt[CSR_TCINT] = 1'b1;
                csr_nxt[CSR_START] = 1'b0;
              end
              csr_nxt[CSR_RDSTINT] = any_ready(status_r);
            end
            OP_UNK_RD: ld_rdata = UNKNOWN_READ;
            OP_DEV_UPD: begin
              ih_we                        = 1'b1;
              ih_wd                        = it.dhigh;
              il_we                        = 1'b1;
              il_wd                        = it.dlow;
              status_nxt[{~it.chan, 3'd5}] = it.dvalid;
              csr_nxt[CSR_RDSTINT]         = any_ready(status_nxt);
            end
            OP_DEV_CHG: begin
              ow_we                        = 1'b1;
              ow_wd                        = '0;
              ih_we                        = 1'b1;
              ih_wd                        = '0;
              il_we                        = 1'b1;
              il_wd                        = '0;
              status_nxt[{~it.chan, 3'd3}] = 1'b1;
              csr_nxt[CSR_COMERR]          = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_BUF: begin
        // Buffer read data arrives in the cycle after the operation left the queue.
        ld_en     = 1'b1;
        ld_rdata  = buf_hit_r ? buf_rdata_r : '0;
        state_nxt = S_IDLE;
      end
      S_CMD: begin
        if (out_free) begin
          ld_en   = 1'b1;
          ld_kind = KIND_CMD;
          ld_tch  = rd_ch;
          ld_cw   = out_words_r[ch_idx];
          ld_pe   = poll_r[5'd7 - 5'(rd_ch)];
          ld_last = (int'(cnt_r) == NUM_CHANNELS - 1);
          cnt_nxt = cnt_r + 2'd1;
          if (ld_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and register state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      poll_r     <= POLL_RESET;
      csr_r      <= '0;
      status_r   <= '0;
      clk_lock_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        out_words_r[i] <= '0;
        in_high_r[i]   <= '0;
        in_low_r[i]    <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      poll_r     <= poll_nxt;
      csr_r      <= csr_nxt;
      status_r   <= status_nxt;
      clk_lock_r <= clk_lock_nxt;
      if (ow_we) begin
        out_words_r[ch_idx] <= ow_wd;
      end
      if (ih_we) begin
        in_high_r[ch_idx] <= ih_wd;
      end
      if (il_we) begin
        in_low_r[ch_idx] <= il_wd;
      end
    end
  end

  // Transfer buffer memory with registered read.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[it.buf_idx] <= it.wdata;
    end
    buf_rdata_r <= buf_mem[it.buf_idx];
    buf_hit_r   <= buf_vld_r[it.buf_idx];
  end

  // Written flags: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= '0;
    end else if (buf_we) begin
      buf_vld_r[it.buf_idx] <= 1'b1;
    end
  end

  // Result register decouples the back end from the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      out_kind_r  <= ld_kind;
      out_rdata_r <= ld_rdata;
      out_tch_r   <= ld_tch;
      out_cw_r    <= ld_cw;
      out_pe_r    <= ld_pe;
      out_il_r    <= ld_il;
      out_ol_r    <= ld_ol;
      out_irq_r   <= irq_of(csr_nxt);
      out_last_r  <= ld_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_read_data      = out_rdata_r;
  assign out_target_channel = out_tch_r;
  assign out_command_word   = out_cw_r;
  assign out_poll_enable    = out_pe_r;
  assign out_in_length      = out_il_r;
  assign out_out_length     = out_ol_r;
  assign out_irq            = out_irq_r;
  assign out_last           = out_last_r;

  // While a command burst is in progress a command is always waiting.
  a_cmd_burst_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMD |-> out_valid_r && out_kind_r == KIND_CMD && !out_last_r)
    else $error("command burst without a pending command result");

  // A buffer read delivers its single result in the next cycle.
  a_buf_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BUF |=> out_valid_r && out_last_r && out_kind_r == KIND_ACK)
    else $error("buffer read result missing");

  // No operation leaves the queue while a burst or buffer read is open.
  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !pop)
    else $error("operation popped while back end busy");

  // Status bits that no operation sets stay clear.
  a_status_unused_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r & STAT_UNUSED) == '0)
    else $error("reserved status bit set");

  // The sequencer state is one-hot.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("back-end state not one-hot");

endmodule

[hdl/serial_channel_register_block.sv]
// Results pass the operation queue and the result register; a buffer read also passes the
// registered buffer memory. Throughput: one item per cycle while results are taken; a
// buffer read or a start-bit status write (one command per channel) holds the back end.
// A two-entry operation queue lets the input side keep accepting while results wait.
// Reset (synchronous, rst_n low) clears the queue, the sequencer, all registers except the
// poll word (0x00070000) and the buffer's written flags; no clearing pass is needed.
module serial_channel_register_block (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_address,
  input  logic [31:0] in_write_data,
  input  logic [1:0]  in_channel,
  input  logic [31:0] in_data_high,
  input  logic [31:0] in_data_low,
  input  logic        in_data_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_target_channel,
  output logic [31:0] out_command_word,
  output logic        out_poll_enable,
  output logic [7:0]  out_in_length,
  output logic [7:0]  out_out_length,
  output logic        out_irq,
  output logic        out_last
);
  import scrb_pkg::*;

  queue_head_t head;
  logic        pop;

  // Front end: classify and queue.
  scrb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_channel    (in_channel),
    .in_data_high  (in_data_high),
    .in_data_low   (in_data_low),
    .in_data_valid (in_data_valid),
    .head          (head),
    .pop           (pop)
  );

  // Back end: execute and deliver results.
  scrb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_read_data      (out_read_data),
    .out_target_channel (out_target_channel),
    .out_command_word   (out_command_word),
    .out_poll_enable    (out_poll_enable),
    .out_in_length      (out_in_length),
    .out_out_length     (out_out_length),
    .out_irq            (out_irq),
    .out_last           (out_last)
  );

endmodule

[test/tb_serial_channel_register_block.sv]
// Self-checking testbench of the serial channel register block.
`timescale 1ns / 100ps

module tb_serial_channel_register_block;
  import scrb_pkg::*;

  // One bus, device-update or device-change item.
  typedef struct {
    cmd_t        cmd;
    logic [7:0]  address;
    logic [31:0] write_data;
    logic [1:0]  channel;
    logic [31:0] data_high;
    logic [31:0] data_low;
    logic        data_valid;
  } bus_item_t;

  // One result as it leaves the block.
  typedef struct {
    kind_t       kind;
    logic [31:0] read_data;
    logic [1:0]  target_channel;
    logic [31:0] command_word;
    logic        poll_enable;
    logic [7:0]  in_length;
    logic [7:0]  out_length;
    logic        irq;
    logic        last;
  } reply_t;

  // Shadow copy of the register file and the replies it predicts.
  class register_scoreboard;
    logic [31:0] out_word [NUM_CHANNELS];
    logic [31:0] in_high [NUM_CHANNELS];
    logic [31:0] in_low [NUM_CHANNELS];
    logic [31:0] poll;
    logic [31:0] csr;
    logic [31:0] status;
    logic [31:0] clock_lock;
    logic [31:0] xfer_mem [BUFFER_WORDS];
    reply_t      expected_q[$];
    int          errors;

    function new();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        out_word[c] = '0;
        in_high[c]  = '0;
        in_low[c]   = '0;
      end
      foreach (xfer_mem[i]) xfer_mem[i] = '0;
      poll       = POLL_RESET;
      csr        = '0;
      status     = '0;
      clock_lock = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // A length field of zero stands for the full 128 bytes.
    function logic [7:0] byte_count(logic [6:0] field);
      return (field == 7'd0) ? 8'd128 : {1'b0, field} + 8'd1;
    endfunction

    // The read-status interrupt follows the ready bits of all channels.
    function void follow_ready();
      csr[CSR_RDSTINT] = |(status & STAT_READY);
    endfunction

    function reply_t blank_reply(kind_t kind);
      reply_t r;
      r.kind           = kind;
      r.read_data      = '0;
      r.target_channel = '0;
      r.command_word   = '0;
      r.poll_enable    = 1'b0;
      r.in_length      = '0;
      r.out_length     = '0;
      r.irq            = 1'b0;
      r.last           = 1'b0;
      return r;
    endfunction

    // Update the shadow registers and queue the replies of one accepted item.
    function void note_input(bus_item_t it);
      reply_t      replies[$];
      reply_t      r;
      logic [31:0] rdata;
      logic [31:0] wd;
      logic [7:0]  a;
      sub_t        sub;
      int          c;
      int          base;
      bit          wr;
      logic        line;

      rdata = '0;
      wd    = it.write_data;
      a     = it.address;
      wr    = (it.cmd == CMD_BUS_WR);
      case (it.cmd)
        CMD_BUS_RD, CMD_BUS_WR: begin
          if (a >= OFS_BUF) begin
            // Buffer: low address bits are ignored.
            c = (a >> 2) % BUFFER_WORDS;
            if (wr) xfer_mem[c] = wd;
            else rdata = xfer_mem[c];
          end else if (a < OFS_POLL && a[1:0] == 2'b00 && a / 12 < NUM_CHANNELS) begin
            c   = a / 12;
            sub = sub_t'(2'((a % 12) / 4));
            if (wr) begin
              case (sub)
                SUB_OUT:     out_word[c] = wd;
                SUB_IN_HIGH: in_high[c]  = wd;
                default:     in_low[c]   = wd;
              endcase
            end else begin
              // Reading either input word consumes the channel's ready bit.
              if (sub != SUB_OUT) begin
                status[24 - 8 * c + 5] = 1'b0;
                follow_ready();
              end
              case (sub)
                SUB_OUT:     rdata = out_word[c];
                SUB_IN_HIGH: rdata = in_high[c];
                default:     rdata = in_low[c];
              endcase
            end
          end else if (a == OFS_POLL) begin
            if (wr) poll = wd;
            else rdata = poll;
          end else if (a == OFS_CLOCK) begin
            if (wr) clock_lock = wd;
            else rdata = clock_lock;
          end else if (a == OFS_STATUS) begin
            if (!wr) begin
              rdata = status;
            end else begin
              // Error bits are write-one-to-clear; the top bit sends all commands.
              status &= ~(wd & STAT_ERR);
              if (wd[STAT_START]) begin
                for (c = 0; c < NUM_CHANNELS; c++) begin
                  r                = blank_reply(KIND_CMD);
                  r.target_channel = c[1:0];
                  r.command_word   = out_word[c];
                  r.poll_enable    = poll[7 - c];
                  replies.push_back(r);
                end
                status &= ~STAT_WR_CLR;
              end
            end
          end else if (a == OFS_CSR) begin
            if (!wr) begin
              rdata = csr;
            end else begin
              csr = (csr & ~CSR_KEEP) | (wd & CSR_KEEP);
              csr[CSR_COMERR] = 1'b0;
              if (wd[CSR_RDSTINT]) csr[CSR_RDSTINT] = 1'b0;
              if (wd[CSR_TCINT]) csr[CSR_TCINT] = 1'b0;
              if (wd[CSR_START]) begin
                r                = blank_reply(KIND_XFER);
                r.target_channel = csr[2:1];
                r.in_length      = byte_count(csr[14:8]);
                r.out_length     = byte_count(csr[22:16]);
                replies.push_back(r);
                csr[CSR_TCINT] = 1'b1;
                csr[CSR_START] = 1'b0;
              end
              follow_ready();
            end
          end else if (!wr) begin
            rdata = UNKNOWN_READ;
          end
        end
        CMD_DEV_UPD: begin
          if (it.channel < NUM_CHANNELS) begin
            c = it.channel;
            in_high[c] = it.data_high;
            in_low[c]  = it.data_low;
            status[24 - 8 * c + 5] = it.data_valid;
            follow_ready();
          end
        end
        default: begin
          // Device change: the channel's words are lost and no-response is flagged.
          if (it.channel < NUM_CHANNELS) begin
            c    = it.channel;
            base = 24 - 8 * c;
            out_word[c] = '0;
            in_high[c]  = '0;
            in_low[c]   = '0;
            status[base + 3] = 1'b1;
            csr[CSR_COMERR]  = 1'b1;
          end
        end
      endcase

      if (replies.size() == 0) begin
        r           = blank_reply(KIND_ACK);
        r.read_data = rdata;
        replies.push_back(r);
      end
      line = (csr[CSR_RDSTINT] & csr[CSR_RDSTINTMK]) | (csr[CSR_TCINT] & csr[CSR_TCINTMSK]);
      foreach (replies[i]) begin
        replies[i].irq  = line;
        replies[i].last = (i == replies.size() - 1);
        expected_q.push_back(replies[i]);
      end
    endfunction

    function int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(reply_t got);
      reply_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %h read_data %h",
                 $time, got.kind, got.read_data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      errors += field_diff("kind", want.kind, got.kind);
      errors += field_diff("read_data", want.read_data, got.read_data);
      errors += field_diff("target_channel", want.target_channel, got.target_channel);
      errors += field_diff("command_word", want.command_word, got.command_word);
      errors += field_diff("poll_enable", want.poll_enable, got.poll_enable);
      errors += field_diff("in_length", want.in_length, got.in_length);
      errors += field_diff("out_length", want.out_length, got.out_length);
      errors += field_diff("irq", want.irq, got.irq);
      errors += field_diff("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = '0;
  logic [7:0]  in_address = '0;
  logic [31:0] in_write_data = '0;
  logic [1:0]  in_channel = '0;
  logic [31:0] in_data_high = '0;
  logic [31:0] in_data_low = '0;
  logic        in_data_valid = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_read_data;
  logic [1:0]  out_target_channel;
  logic [31:0] out_command_word;
  logic        out_poll_enable;
  logic [7:0]  out_in_length;
  logic [7:0]  out_out_length;
  logic        out_irq;
  logic        out_last;

  register_scoreboard sb;
  int burst_left;
  int ready_mode;
  int ready_span;
  int ready_tick;

  serial_channel_register_block i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_channel         (in_channel),
    .in_data_high       (in_data_high),
    .in_data_low        (in_data_low),
    .in_data_valid      (in_data_valid),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_read_data      (out_read_data),
    .out_target_channel (out_target_channel),
    .out_command_word   (out_command_word),
    .out_poll_enable    (out_poll_enable),
    .out_in_length      (out_in_length),
    .out_out_length     (out_out_length),
    .out_irq            (out_irq),
    .out_last           (out_last)
  );

  always #2 clk = ~clk;

  // Receiver: switches between randomly chosen stall patterns.
  always @(posedge clk) begin
    if (ready_span <= 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_span = $urandom_range(16, 80);
    end
    ready_span--;
    ready_tick++;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ready_tick[1];
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Result monitor.
  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind           = kind_t'(out_kind);
      got.read_data      = out_read_data;
      got.target_channel = out_target_channel;
      got.command_word   = out_command_word;
      got.poll_enable    = out_poll_enable;
      got.in_length      = out_in_length;
      got.out_length     = out_out_length;
      got.irq            = out_irq;
      got.last           = out_last;
      sb.check_result(got);
    end
  end

  function automatic bus_item_t make_item(cmd_t cmd, logic [7:0] a, logic [31:0] wd,
                                          logic [1:0] ch = '0, logic [31:0] dh = '0,
                                          logic [31:0] dl = '0, logic dv = 1'b0);
    bus_item_t it;
    it.cmd        = cmd;
    it.address    = a;
    it.write_data = wd;
    it.channel    = ch;
    it.data_high  = dh;
    it.data_low   = dl;
    it.data_valid = dv;
    return it;
  endfunction

  // Random item: mostly register traffic at real offsets, some device events and noise.
  function automatic bus_item_t random_item();
    bus_item_t it;
    int pick;
    it = make_item(CMD_BUS_RD, 8'($urandom), $urandom, 2'($urandom), $urandom, $urandom,
                   1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.cmd = CMD_DEV_UPD;
    end else if (pick < 16) begin
      it.cmd = CMD_DEV_CHG;
    end else begin
      it.cmd = ($urandom_range(0, 1) == 1) ? CMD_BUS_WR : CMD_BUS_RD;
      pick = $urandom_range(0, 99);
      if (pick < 30)      it.address = 8'($urandom_range(0, 11) * 4);
      else if (pick < 40) it.address = OFS_POLL;
      else if (pick < 50) it.address = OFS_CSR;
      else if (pick < 62) it.address = OFS_STATUS;
      else if (pick < 67) it.address = OFS_CLOCK;
      else if (pick < 85) it.address = 8'($urandom_range(128, 255));
      if (it.address == OFS_STATUS) it.write_data[STAT_START] = ($urandom_range(0, 2) == 0);
    end
    return it;
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(bus_item_t it);
    in_valid      <= 1'b1;
    in_cmd        <= it.cmd;
    in_address    <= it.address;
    in_write_data <= it.write_data;
    in_channel    <= it.channel;
    in_data_high  <= it.data_high;
    in_data_low   <= it.data_low;
    in_data_valid <= it.data_valid;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Send within the current burst; between bursts the sender may go quiet.
  task automatic push_item(bus_item_t it);
    int gap;
    send_item(it);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 2);
        2:       gap = $urandom_range(3, 8);
        default: gap = $urandom_range(0, 20);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    bus_item_t directed[$];
    sb         = new();
    burst_left = 4;
    ready_span = 0;
    ready_tick = 0;

    // Directed part: reset values, each kind of register, interrupts, lengths and events.
    directed.push_back(make_item(CMD_BUS_RD, OFS_POLL, '0));
    directed.push_back(make_item(CMD_BUS_RD, OFS_STATUS, '0));
    directed.push_back(make_item(CMD_BUS_WR, 8'h00, 32'hFFFF_FFFF));
    directed.push_back(make_item(CMD_BUS_WR, 8'h24, 32'h1234_5678));
    directed.push_back(make_item(CMD_BUS_WR, OFS_POLL, 32'h0000_00A0));
    directed.push_back(make_item(CMD_DEV_UPD, '0, '0, 2'd2, 32'hFFFF_FFFF, 32'h0, 1'b1));
    directed.push_back(make_item(CMD_DEV_UPD, '0, '0, 2'd3, 32'h0, 32'hFFFF_FFFF, 1'b0));
    directed.push_back(make_item(CMD_BUS_RD, OFS_CSR, '0));
    directed.push_back(make_item(CMD_BUS_WR, OFS_CSR, 32'hC800_0001));
    directed.push_back(make_item(CMD_BUS_WR, OFS_CSR, 32'h407F_7F07));
    directed.push_back(make_item(CMD_BUS_WR, OFS_CSR, 32'h8000_0102));
    directed.push_back(make_item(CMD_BUS_RD, 8'h1C, '0));
    directed.push_back(make_item(CMD_BUS_RD, 8'h20, '0));
    directed.push_back(make_item(CMD_DEV_CHG, '0, '0, 2'd1));
    directed.push_back(make_item(CMD_BUS_RD, OFS_STATUS, '0));
    directed.push_back(make_item(CMD_BUS_WR, OFS_STATUS, 32'hFFFF_FFFF));
    directed.push_back(make_item(CMD_BUS_WR, OFS_STATUS, 32'h0000_0000));
    directed.push_back(make_item(CMD_BUS_RD, 8'h40, '0));
    directed.push_back(make_item(CMD_BUS_RD, 8'h31, '0));
    directed.push_back(make_item(CMD_BUS_WR, 8'h7C, 32'hFFFF_FFFF));
    directed.push_back(make_item(CMD_BUS_WR, 8'hFF, 32'hFFFF_FFFF));
    directed.push_back(make_item(CMD_BUS_RD, 8'hFC, '0));
    directed.push_back(make_item(CMD_BUS_RD, 8'h80, '0));
    directed.push_back(make_item(CMD_BUS_WR, OFS_CLOCK, 32'h8000_0001));
    directed.push_back(make_item(CMD_BUS_RD, OFS_CLOCK, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) push_item(directed[i]);
    drain_outputs();

    for (int i = 0; i < 185; i++) begin
      push_item(random_item());
      if (i == 92) drain_outputs();
    end
    drain_outputs();

    // Allow for any straggling result.
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** serial_channel_register_block: PASSED **");
    end else begin
      $display("** serial_channel_register_block: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("** serial_channel_register_block: FAILED **");
    $finish;
  end

endmodule
